@@ hdl/ssc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// ssc_pkg
// Shared constants for the scroll speed classifier: class codes, register
// indexes, register reset values and field widths.
// ---------------------------------------------------------------------------
package ssc_pkg;

   localparam int DEFAULT_HISTORY_DEPTH = 16;

   localparam int POS_W    = 24;
   localparam int TIME_W   = 32;
   localparam int LIMIT_W  = 16;
   localparam int MARGIN_W = 12;
   localparam int HELD_W   = 5;
   localparam int CLASS_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // pixels per ms to pixels per s
   localparam int SCALE_W = 10;
   localparam logic [SCALE_W-1:0] SPEED_SCALE = 10'd1000;

   localparam logic [CLASS_W-1:0] CLS_IDLE  = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_SLOW  = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_FAST  = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_FLING = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLING_SPAN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FLING_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_MARGIN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_MARGIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_MARGIN = 3'd7;

   localparam logic [LIMIT_W-1:0]  RST_WINDOW      = 16'd200;
   localparam logic [LIMIT_W-1:0]  RST_FLING_SPAN  = 16'd50;
   localparam logic [LIMIT_W-1:0]  RST_SLOW_LIMIT  = 16'd500;
   localparam logic [LIMIT_W-1:0]  RST_FAST_LIMIT  = 16'd1000;
   localparam logic [LIMIT_W-1:0]  RST_FLING_LIMIT = 16'd3000;
   localparam logic [MARGIN_W-1:0] RST_IDLE_MARGIN = 12'd1200;
   localparam logic [MARGIN_W-1:0] RST_SLOW_MARGIN = 12'd800;
   localparam logic [MARGIN_W-1:0] RST_FAST_MARGIN = 12'd400;

endpackage
`default_nettype wire

@@ hdl/scroll_speed_classifier_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// scroll_speed_classifier_top
// Classifies scroll speed from a bounded history of timestamped positions.
//
// Usage:
//  - req_* channel (valid/ready) carries one transaction per event: a
//    position sample (kind 0) or a history clear (kind 1).
//  - rsp_* channel (valid/ready) returns exactly one transaction per request:
//    motion class, preload margin and the number of entries kept.
//  - csr_* is a plain write port; write only while the block is idle.
//  - One request at a time; a clear goes straight to its result, while a
//    sample waits on the prune loop over the history memory, which reads
//    and checks the oldest entry once per entry aged out (one read per
//    check), so a sample's delay grows with the entries aged out.
//  - The result sits in an output register, so the next request is accepted
//    while a result waits; a stalled receiver holds the block only when a
//    second result is ready to be loaded.
//  - Synchronous reset empties the history (count and oldest pointer only)
//    and restores the register defaults; no clearing pass is needed.
// ---------------------------------------------------------------------------
module scroll_speed_classifier_top #(
   parameter int HISTORY_DEPTH = ssc_pkg::DEFAULT_HISTORY_DEPTH
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire                              req_kind,
   input  wire  [ssc_pkg::POS_W-1:0]        req_position,
   input  wire  [ssc_pkg::TIME_W-1:0]       req_time_ms,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output logic [ssc_pkg::CLASS_W-1:0]      rsp_motion_class,
   output logic [ssc_pkg::MARGIN_W-1:0]     rsp_preload_margin,
   output logic [ssc_pkg::HELD_W-1:0]       rsp_samples_held,
   input  wire                              csr_we,
   input  wire  [ssc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire  [ssc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W   = IDX_W + 2;
   localparam int ENTRY_W = ssc_pkg::POS_W + ssc_pkg::TIME_W;
   localparam int LHS_W   = ssc_pkg::POS_W + ssc_pkg::SCALE_W;
   localparam int PROD_W  = ssc_pkg::LIMIT_W + ssc_pkg::TIME_W;

   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(HISTORY_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(HISTORY_DEPTH);
   localparam logic [CNT_W-1:0] TWO_COUNT  = CNT_W'(2);
   localparam logic [SUM_W-1:0] DEPTH_SUM  = SUM_W'(HISTORY_DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_CHECK = 3'd2;
   localparam logic [2:0] ST_LHS   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   localparam logic [1:0] SEL_LAST = 2'd2;

   // configuration
   logic [ssc_pkg::LIMIT_W-1:0]  window_ff, fling_span_ff;
   logic [ssc_pkg::LIMIT_W-1:0]  slow_limit_ff, fast_limit_ff, fling_limit_ff;
   logic [ssc_pkg::MARGIN_W-1:0] idle_margin_ff, slow_margin_ff, fast_margin_ff;

   // control
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   logic [ssc_pkg::POS_W-1:0]   pos_ff, pos_in;
   logic [ssc_pkg::TIME_W-1:0]  now_ff, now_in;
   logic [ssc_pkg::TIME_W-1:0]  span_ff, span_in;
   logic [ssc_pkg::POS_W-1:0]   dist_ff, dist_in;
   logic [LHS_W-1:0]            lhs_ff, lhs_in;
   logic [1:0]                  sel_ff, sel_in;
   logic [ssc_pkg::CLASS_W-1:0] cls_ff, cls_in;

   logic [ssc_pkg::CLASS_W-1:0]  rsp_class_ff;
   logic [ssc_pkg::MARGIN_W-1:0] rsp_margin_ff, margin_sel;
   logic [ssc_pkg::HELD_W-1:0]   rsp_held_ff;
   logic [CNT_W+ssc_pkg::HELD_W-1:0] held_wide;

   // history memory
   logic [ENTRY_W-1:0] hist_mem [HISTORY_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   logic [ssc_pkg::TIME_W-1:0] rd_time, age;
   logic [ssc_pkg::POS_W-1:0]  rd_pos;
   logic [IDX_W-1:0]           oldest_adv, base_oldest;
   logic [CNT_W-1:0]           base_count;
   logic [SUM_W-1:0]           slot_sum, slot_wrap;
   logic [ssc_pkg::LIMIT_W-1:0] limit_sel;
   logic [PROD_W-1:0]          prod;
   logic                       load_rsp, full;

   assign req_ready          = (state_ff == ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_motion_class   = rsp_class_ff;
   assign rsp_preload_margin = rsp_margin_ff;
   assign rsp_samples_held   = rsp_held_ff;

   assign rd_time = rd_data_ff[ssc_pkg::TIME_W-1:0];
   assign rd_pos  = rd_data_ff[ENTRY_W-1:ssc_pkg::TIME_W];
   assign age     = now_ff - rd_time;

   assign full        = (count_ff == FULL_COUNT);
   assign oldest_adv  = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + 1'b1;
   assign base_oldest = full ? oldest_adv : oldest_ff;
   assign base_count  = full ? count_ff - 1'b1 : count_ff;
   assign slot_sum    = {{(SUM_W-IDX_W){1'b0}}, base_oldest}
                      + {{(SUM_W-CNT_W){1'b0}}, base_count};
   assign slot_wrap   = (slot_sum >= DEPTH_SUM) ? slot_sum - DEPTH_SUM : slot_sum;

   always_comb begin
      unique case (sel_ff)
         2'd0:    limit_sel = slow_limit_ff;
         2'd1:    limit_sel = fast_limit_ff;
         default: limit_sel = fling_limit_ff;
      endcase
   end

   assign prod = PROD_W'(limit_sel) * PROD_W'(span_ff);

   always_comb begin
      unique case (cls_ff)
         ssc_pkg::CLS_IDLE:  margin_sel = idle_margin_ff;
         ssc_pkg::CLS_SLOW:  margin_sel = slow_margin_ff;
         ssc_pkg::CLS_FAST:  margin_sel = fast_margin_ff;
         ssc_pkg::CLS_FLING: margin_sel = '0;
      endcase
   end

   assign held_wide = {{ssc_pkg::HELD_W{1'b0}}, count_ff};

   always_comb begin
      state_in  = state_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      now_in    = now_ff;
      span_in   = span_ff;
      dist_in   = dist_ff;
      lhs_in    = lhs_ff;
      sel_in    = sel_ff;
      cls_in    = cls_ff;
      mem_we    = 1'b0;
      mem_waddr = slot_wrap[IDX_W-1:0];
      mem_wdata = {req_position, req_time_ms};
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind) begin
                  count_in  = '0;
                  oldest_in = '0;
                  cls_in    = ssc_pkg::CLS_IDLE;
                  state_in  = ST_DONE;
               end else begin
                  mem_we    = 1'b1;
                  oldest_in = base_oldest;
                  count_in  = base_count + 1'b1;
                  pos_in    = req_position;
                  now_in    = req_time_ms;
                  state_in  = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (age > {{(ssc_pkg::TIME_W-ssc_pkg::LIMIT_W){1'b0}}, window_ff}) begin
               oldest_in = oldest_adv;
               count_in  = count_ff - 1'b1;
               state_in  = ST_READ;
            end else begin
               span_in = age;
               dist_in = (pos_ff >= rd_pos) ? pos_ff - rd_pos : rd_pos - pos_ff;
               if (count_ff < TWO_COUNT) begin
                  cls_in   = ssc_pkg::CLS_IDLE;
                  state_in = ST_DONE;
               end else if (age < {{(ssc_pkg::TIME_W-ssc_pkg::LIMIT_W){1'b0}},
                                   fling_span_ff}) begin
                  cls_in   = ssc_pkg::CLS_FLING;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_LHS;
               end
            end
         end
         ST_LHS: begin
            lhs_in   = LHS_W'(dist_ff) * LHS_W'(ssc_pkg::SPEED_SCALE);
            sel_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // limit order slow, fast, fling maps onto classes idle, slow, fast
            if ({{(PROD_W-LHS_W){1'b0}}, lhs_ff} < prod) begin
               cls_in   = sel_ff;
               state_in = ST_DONE;
            end else if (sel_ff == SEL_LAST) begin
               cls_in   = ssc_pkg::CLS_FLING;
               state_in = ST_DONE;
            end else begin
               sel_in = sel_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= hist_mem[oldest_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      now_ff  <= now_in;
      span_ff <= span_in;
      dist_ff <= dist_in;
      lhs_ff  <= lhs_in;
      sel_ff  <= sel_in;
      cls_ff  <= cls_in;
      if (load_rsp) begin
         rsp_class_ff  <= cls_ff;
         rsp_margin_ff <= margin_sel;
         rsp_held_ff   <= held_wide[ssc_pkg::HELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff      <= ssc_pkg::RST_WINDOW;
         fling_span_ff  <= ssc_pkg::RST_FLING_SPAN;
         slow_limit_ff  <= ssc_pkg::RST_SLOW_LIMIT;
         fast_limit_ff  <= ssc_pkg::RST_FAST_LIMIT;
         fling_limit_ff <= ssc_pkg::RST_FLING_LIMIT;
         idle_margin_ff <= ssc_pkg::RST_IDLE_MARGIN;
         slow_margin_ff <= ssc_pkg::RST_SLOW_MARGIN;
         fast_margin_ff <= ssc_pkg::RST_FAST_MARGIN;
      end else if (csr_we) begin
         unique case (csr_index)
            ssc_pkg::CSR_WINDOW:      window_ff      <= csr_wdata;
            ssc_pkg::CSR_FLING_SPAN:  fling_span_ff  <= csr_wdata;
            ssc_pkg::CSR_SLOW_LIMIT:  slow_limit_ff  <= csr_wdata;
            ssc_pkg::CSR_FAST_LIMIT:  fast_limit_ff  <= csr_wdata;
            ssc_pkg::CSR_FLING_LIMIT: fling_limit_ff <= csr_wdata;
            ssc_pkg::CSR_IDLE_MARGIN: idle_margin_ff <= csr_wdata[ssc_pkg::MARGIN_W-1:0];
            ssc_pkg::CSR_SLOW_MARGIN: slow_margin_ff <= csr_wdata[ssc_pkg::MARGIN_W-1:0];
            ssc_pkg::CSR_FAST_MARGIN: fast_margin_ff <= csr_wdata[ssc_pkg::MARGIN_W-1:0];
         endcase
      end
   end

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("history count above depth");

   a_oldest_bound: assert property (@(posedge clock) disable iff (reset)
      oldest_ff <= LAST_SLOT)
      else $error("oldest pointer out of range");

   a_prune_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK) |-> (count_ff != '0))
      else $error("history emptied during prune");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_kind) |=> (count_ff == '0 && oldest_ff == '0))
      else $error("clear transaction left history entries");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

endmodule
`default_nettype wire

@@ tb/sv/scroll_speed_classifier_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// scroll_speed_classifier_top_tb
// Self-checking bench for the scroll speed classifier. A scoreboard keeps
// its own copy of the sample history and registers and predicts one
// classification per accepted request. A directed run hits the field
// extremes and the corner cases. Random gestures follow: runs of samples at
// a chosen speed, with time jumps, backward timestamps, wraps and clears,
// under several register settings. The sender idles in bursts, and the
// receiver stalls in patterns, with two long hold-offs.
// ---------------------------------------------------------------------------
module scroll_speed_classifier_top_tb;

   localparam int DEPTH        = ssc_pkg::DEFAULT_HISTORY_DEPTH;
   localparam int CLK_HALF     = 6;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 175;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int JUNK_W       = ssc_pkg::CSR_DATA_W - ssc_pkg::MARGIN_W;

   typedef struct packed {
      logic [ssc_pkg::CLASS_W-1:0]  motion_class;
      logic [ssc_pkg::MARGIN_W-1:0] preload_margin;
      logic [ssc_pkg::HELD_W-1:0]   samples_held;
   } classification_type;

   typedef struct {
      logic [ssc_pkg::LIMIT_W-1:0]  window_ms;
      logic [ssc_pkg::LIMIT_W-1:0]  fling_span_ms;
      logic [ssc_pkg::LIMIT_W-1:0]  slow_limit;
      logic [ssc_pkg::LIMIT_W-1:0]  fast_limit;
      logic [ssc_pkg::LIMIT_W-1:0]  fling_limit;
      logic [ssc_pkg::MARGIN_W-1:0] idle_margin;
      logic [ssc_pkg::MARGIN_W-1:0] slow_margin;
      logic [ssc_pkg::MARGIN_W-1:0] fast_margin;
   } csr_set_type;

   typedef enum {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_type;

   class classifier_scoreboard;
      logic [ssc_pkg::POS_W-1:0]    hist_pos  [DEPTH];
      logic [ssc_pkg::TIME_W-1:0]   hist_time [DEPTH];
      int unsigned                  oldest;
      int unsigned                  held;
      logic [ssc_pkg::LIMIT_W-1:0]  window_ms;
      logic [ssc_pkg::LIMIT_W-1:0]  fling_span_ms;
      logic [ssc_pkg::LIMIT_W-1:0]  slow_limit;
      logic [ssc_pkg::LIMIT_W-1:0]  fast_limit;
      logic [ssc_pkg::LIMIT_W-1:0]  fling_limit;
      logic [ssc_pkg::MARGIN_W-1:0] idle_margin;
      logic [ssc_pkg::MARGIN_W-1:0] slow_margin;
      logic [ssc_pkg::MARGIN_W-1:0] fast_margin;
      classification_type           expected_classes[$];
      int unsigned                  errors;
      int unsigned                  requests;
      int unsigned                  responses;
      int unsigned                  class_count[4];

      function new();
         oldest        = 0;
         held          = 0;
         window_ms     = ssc_pkg::RST_WINDOW;
         fling_span_ms = ssc_pkg::RST_FLING_SPAN;
         slow_limit    = ssc_pkg::RST_SLOW_LIMIT;
         fast_limit    = ssc_pkg::RST_FAST_LIMIT;
         fling_limit   = ssc_pkg::RST_FLING_LIMIT;
         idle_margin   = ssc_pkg::RST_IDLE_MARGIN;
         slow_margin   = ssc_pkg::RST_SLOW_MARGIN;
         fast_margin   = ssc_pkg::RST_FAST_MARGIN;
         errors        = 0;
         requests      = 0;
         responses     = 0;
         foreach (class_count[i]) class_count[i] = 0;
      endfunction

      function void write_reg(logic [ssc_pkg::CSR_IDX_W-1:0] idx,
                              logic [ssc_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            ssc_pkg::CSR_WINDOW:      window_ms     = data;
            ssc_pkg::CSR_FLING_SPAN:  fling_span_ms = data;
            ssc_pkg::CSR_SLOW_LIMIT:  slow_limit    = data;
            ssc_pkg::CSR_FAST_LIMIT:  fast_limit    = data;
            ssc_pkg::CSR_FLING_LIMIT: fling_limit   = data;
            ssc_pkg::CSR_IDLE_MARGIN: idle_margin   = data[ssc_pkg::MARGIN_W-1:0];
            ssc_pkg::CSR_SLOW_MARGIN: slow_margin   = data[ssc_pkg::MARGIN_W-1:0];
            ssc_pkg::CSR_FAST_MARGIN: fast_margin   = data[ssc_pkg::MARGIN_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [ssc_pkg::MARGIN_W-1:0] margin_for(logic [ssc_pkg::CLASS_W-1:0] cls);
         case (cls)
            ssc_pkg::CLS_IDLE: return idle_margin;
            ssc_pkg::CLS_SLOW: return slow_margin;
            ssc_pkg::CLS_FAST: return fast_margin;
            default:           return '0;
         endcase
      endfunction

      function void note_event(logic kind, logic [ssc_pkg::POS_W-1:0] pos,
                               logic [ssc_pkg::TIME_W-1:0] now);
         int unsigned                 slot;
         logic [ssc_pkg::TIME_W-1:0]  age;
         logic [ssc_pkg::TIME_W-1:0]  span;
         logic [ssc_pkg::POS_W-1:0]   first_pos;
         logic [ssc_pkg::POS_W-1:0]   pos_delta;
         logic [63:0]                 scaled;
         logic [ssc_pkg::CLASS_W-1:0] cls;
         classification_type          res;
         cls = ssc_pkg::CLS_IDLE;
         requests++;
         if (kind) begin
            held   = 0;
            oldest = 0;
         end else begin
            if (held >= DEPTH) begin
               oldest = (oldest + 1) % DEPTH;
               held--;
            end
            slot = (oldest + held) % DEPTH;
            hist_pos[slot]  = pos;
            hist_time[slot] = now;
            held++;
            age = now - hist_time[oldest];
            while (held > 0 && age > ssc_pkg::TIME_W'(window_ms)) begin
               oldest = (oldest + 1) % DEPTH;
               held--;
               if (held > 0) age = now - hist_time[oldest];
            end
            if (held >= 2) begin
               first_pos = hist_pos[oldest];
               span      = now - hist_time[oldest];
               pos_delta = (pos >= first_pos) ? pos - first_pos : first_pos - pos;
               scaled    = 64'(pos_delta) * 64'(ssc_pkg::SPEED_SCALE);
               if (span < ssc_pkg::TIME_W'(fling_span_ms))
                  cls = ssc_pkg::CLS_FLING;
               else if (scaled < 64'(slow_limit) * 64'(span))
                  cls = ssc_pkg::CLS_IDLE;
               else if (scaled < 64'(fast_limit) * 64'(span))
                  cls = ssc_pkg::CLS_SLOW;
               else if (scaled < 64'(fling_limit) * 64'(span))
                  cls = ssc_pkg::CLS_FAST;
               else
                  cls = ssc_pkg::CLS_FLING;
            end
         end
         res.motion_class   = cls;
         res.preload_margin = margin_for(cls);
         res.samples_held   = ssc_pkg::HELD_W'(held);
         expected_classes.push_back(res);
      endfunction

      function void check_classification(logic [ssc_pkg::CLASS_W-1:0] cls,
                                         logic [ssc_pkg::MARGIN_W-1:0] margin,
                                         logic [ssc_pkg::HELD_W-1:0] held_out);
         classification_type want;
         responses++;
         if (expected_classes.size() == 0) begin
            $error("unexpected response transaction: class %0d margin %0d held %0d",
                   cls, margin, held_out);
            errors++;
            return;
         end
         want = expected_classes.pop_front();
         class_count[want.motion_class]++;
         if (cls !== want.motion_class) begin
            $error("motion_class mismatch: expected %0d, actual %0d", want.motion_class, cls);
            errors++;
         end
         if (margin !== want.preload_margin) begin
            $error("preload_margin mismatch: expected %0d, actual %0d",
                   want.preload_margin, margin);
            errors++;
         end
         if (held_out !== want.samples_held) begin
            $error("samples_held mismatch: expected %0d, actual %0d",
                   want.samples_held, held_out);
            errors++;
         end
      endfunction

      function int pending();
         return expected_classes.size();
      endfunction
   endclass

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   wire                            req_ready;
   logic                           req_kind     = 1'b0;
   logic [ssc_pkg::POS_W-1:0]      req_position = '0;
   logic [ssc_pkg::TIME_W-1:0]     req_time_ms  = '0;
   wire                            rsp_valid;
   logic                           rsp_ready    = 1'b0;
   wire [ssc_pkg::CLASS_W-1:0]     rsp_motion_class;
   wire [ssc_pkg::MARGIN_W-1:0]    rsp_preload_margin;
   wire [ssc_pkg::HELD_W-1:0]      rsp_samples_held;
   logic                           csr_we       = 1'b0;
   logic [ssc_pkg::CSR_IDX_W-1:0]  csr_index    = ssc_pkg::CSR_WINDOW;
   logic [ssc_pkg::CSR_DATA_W-1:0] csr_wdata    = '0;

   classifier_scoreboard       sb;
   int                         cycle_count;
   int                         burst_left;
   bit                         req_held;
   int                         settings_applied;
   logic [ssc_pkg::TIME_W-1:0] cur_time;
   logic [ssc_pkg::POS_W-1:0]  cur_pos;

   scroll_speed_classifier_top u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_kind           (req_kind),
      .req_position       (req_position),
      .req_time_ms        (req_time_ms),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_motion_class   (rsp_motion_class),
      .rsp_preload_margin (rsp_preload_margin),
      .rsp_samples_held   (rsp_samples_held),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_classification(rsp_motion_class, rsp_preload_margin, rsp_samples_held);
   end

   // receiver: stall patterns, plus two long hold-offs to back up the input
   initial begin : receiver
      rx_mode_type mode;
      int          run_len;
      int          holds_done;
      int          tick;
      holds_done = 0;
      tick       = 0;
      wait (reset == 1'b0);
      forever begin
         mode    = rx_mode_type'($urandom_range(0, 3));
         run_len = $urandom_range(4, 80);
         repeat (run_len) begin
            @(negedge clock);
            tick++;
            if (holds_done < 2 && sb.responses >= (holds_done == 0 ? 250 : 900)) begin
               rsp_ready <= 1'b0;
               holds_done++;
               repeat (HOLD_CYCLES) @(negedge clock);
            end else begin
               case (mode)
                  RX_ALWAYS:   rsp_ready <= 1'b1;
                  RX_COIN:     rsp_ready <= ($urandom_range(0, 1) == 1);
                  RX_SPARSE:   rsp_ready <= ($urandom_range(0, 7) == 0);
                  default:     rsp_ready <= (tick % 3 != 0);
               endcase
            end
         end
      end
   end

   // called at a falling edge; returns at a falling edge
   task automatic send_request(input logic kind, input logic [ssc_pkg::POS_W-1:0] pos,
                               input logic [ssc_pkg::TIME_W-1:0] t);
      req_valid    <= 1'b1;
      req_kind     <= kind;
      req_position <= pos;
      req_time_ms  <= t;
      do @(posedge clock); while (!req_ready);
      sb.note_event(kind, pos, t);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
         req_held = 1'b1;
      end else begin
         req_valid <= 1'b0;
         req_held = 1'b0;
         repeat ($urandom_range(1, 20)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic settle();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [ssc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ssc_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   // upper bits of a margin write are don't-care; make them noisy
   function automatic logic [ssc_pkg::CSR_DATA_W-1:0] pad_margin(
      input logic [ssc_pkg::MARGIN_W-1:0] m);
      logic [JUNK_W-1:0] junk;
      junk = JUNK_W'($urandom());
      return {junk, m};
   endfunction

   task automatic apply_settings(input csr_set_type s);
      csr_write(ssc_pkg::CSR_WINDOW,      s.window_ms);
      csr_write(ssc_pkg::CSR_FLING_SPAN,  s.fling_span_ms);
      csr_write(ssc_pkg::CSR_SLOW_LIMIT,  s.slow_limit);
      csr_write(ssc_pkg::CSR_FAST_LIMIT,  s.fast_limit);
      csr_write(ssc_pkg::CSR_FLING_LIMIT, s.fling_limit);
      csr_write(ssc_pkg::CSR_IDLE_MARGIN, pad_margin(s.idle_margin));
      csr_write(ssc_pkg::CSR_SLOW_MARGIN, pad_margin(s.slow_margin));
      csr_write(ssc_pkg::CSR_FAST_MARGIN, pad_margin(s.fast_margin));
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   function automatic logic [ssc_pkg::LIMIT_W-1:0] pick_limit(input int lo, input int typ_hi);
      case ($urandom_range(0, 5))
         0:       return ssc_pkg::LIMIT_W'(lo);
         1:       return '1;
         default: return ssc_pkg::LIMIT_W'($urandom_range(lo, typ_hi));
      endcase
   endfunction

   function automatic logic [ssc_pkg::MARGIN_W-1:0] pick_margin();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return ssc_pkg::MARGIN_W'($urandom());
      endcase
   endfunction

   function automatic csr_set_type pick_settings(input int phase);
      csr_set_type s;
      case (phase)
         0: begin
            s.window_ms   = ssc_pkg::RST_WINDOW;
            s.fling_span_ms = ssc_pkg::RST_FLING_SPAN;
            s.slow_limit  = ssc_pkg::RST_SLOW_LIMIT;
            s.fast_limit  = ssc_pkg::RST_FAST_LIMIT;
            s.fling_limit = ssc_pkg::RST_FLING_LIMIT;
            s.idle_margin = ssc_pkg::RST_IDLE_MARGIN;
            s.slow_margin = ssc_pkg::RST_SLOW_MARGIN;
            s.fast_margin = ssc_pkg::RST_FAST_MARGIN;
         end
         1: begin
            s.window_ms   = '1; s.fling_span_ms = '0;
            s.slow_limit  = '1; s.fast_limit    = '1; s.fling_limit = '1;
            s.idle_margin = '1; s.slow_margin   = '1; s.fast_margin = '1;
         end
         2: begin
            s.window_ms   = 1;  s.fling_span_ms = '0;
            s.slow_limit  = '0; s.fast_limit    = '0; s.fling_limit = '0;
            s.idle_margin = '0; s.slow_margin   = '0; s.fast_margin = '0;
         end
         3: begin
            // limits out of order
            s.window_ms   = 400;  s.fling_span_ms = 20;
            s.slow_limit  = 3000; s.fast_limit    = 1000; s.fling_limit = 500;
            s.idle_margin = pick_margin(); s.slow_margin = pick_margin();
            s.fast_margin = pick_margin();
         end
         default: begin
            s.window_ms     = pick_limit(1, 2000);
            s.fling_span_ms = pick_limit(0, 100);
            s.slow_limit    = pick_limit(0, 20000);
            s.fast_limit    = pick_limit(0, 20000);
            s.fling_limit   = pick_limit(0, 20000);
            s.idle_margin   = pick_margin();
            s.slow_margin   = pick_margin();
            s.fast_margin   = pick_margin();
         end
      endcase
      return s;
   endfunction

   task automatic run_directed();
      csr_set_type s;
      send_request(1'b1, '1, '1);
      send_request(1'b0, 24'd0, 32'd100);
      send_request(1'b0, 24'd0, 32'd100);      // zero span, fling
      send_request(1'b0, 24'd10, 32'd200);     // idle
      send_request(1'b0, 24'd70, 32'd200);     // slow
      send_request(1'b0, 24'd250, 32'd200);    // fast
      send_request(1'b0, 24'd400, 32'd200);    // fling by speed
      send_request(1'b0, '1, 32'd350);         // ages out the two oldest
      send_request(1'b0, 24'd5, 32'd150);      // time goes backward
      send_request(1'b1, '0, '0);
      send_request(1'b0, 24'd0, 32'hFFFF_FFF0);
      send_request(1'b0, 24'd100, 32'h0000_0050); // across the wrap
      send_request(1'b0, '1, 32'h0000_0090);

      settle();
      s.window_ms   = '1; s.fling_span_ms = '0;
      s.slow_limit  = '0; s.fast_limit    = '1; s.fling_limit = '1;
      s.idle_margin = '1; s.slow_margin   = '0; s.fast_margin = '1;
      apply_settings(s);
      send_request(1'b1, 24'h5A_5A5A, 32'hA5A5_A5A5);
      send_request(1'b0, 24'd123, 32'd7777);
      send_request(1'b0, 24'd123, 32'd7777);   // zero span with zero minimum
      send_request(1'b0, 24'd200, 32'd7877);

      settle();
      s.window_ms   = 1;  s.fling_span_ms = '1;
      s.slow_limit  = '1; s.fast_limit    = '1; s.fling_limit = '1;
      s.idle_margin = '0; s.slow_margin   = '0; s.fast_margin = '0;
      apply_settings(s);
      send_request(1'b0, 24'd0, 32'd0);
      send_request(1'b0, 24'd1, 32'd1);
      send_request(1'b0, 24'd2, 32'd3);
   endtask

   // gestures: runs of samples at one speed, with noise and clears mixed in
   task automatic run_random(input int count);
      int          n;
      int          len;
      int          speed;
      int          dt;
      int          max_dt;
      int          i;
      bit          descending;
      logic [63:0] step;
      n = 0;
      while (n < count) begin
         if ($urandom_range(0, 9) == 0) begin
            send_request(($urandom_range(0, 2) == 0), ssc_pkg::POS_W'($urandom()),
                         $urandom());
            n++;
         end else begin
            len        = $urandom_range(2, 30);
            descending = ($urandom_range(0, 1) == 1);
            case ($urandom_range(0, 2))
               0:       speed = $urandom_range(0, 1200);
               1:       speed = $urandom_range(0, 6000);
               default: speed = $urandom_range(0, 80000);
            endcase
            if ($urandom_range(0, 3) == 0)
               cur_time = $urandom();
            else if ($urandom_range(0, 9) == 0)
               cur_time = 32'hFFFF_FFFF - $urandom_range(0, 400);
            if ($urandom_range(0, 4) == 0) cur_pos = ssc_pkg::POS_W'($urandom());
            max_dt = int'(sb.window_ms) / 6 + 2;
            if (max_dt > 60) max_dt = 60;
            for (i = 0; i < len && n < count; i++) begin
               case ($urandom_range(0, 39))
                  0:       dt = $urandom_range(0, 70000);
                  1:       dt = -int'($urandom_range(1, 500));
                  default: dt = $urandom_range(0, max_dt);
               endcase
               cur_time = cur_time + ssc_pkg::TIME_W'(dt);
               step = (dt > 0) ? (64'(speed) * 64'(dt)) / 1000 + $urandom_range(0, 1) : '0;
               cur_pos = descending ? cur_pos - ssc_pkg::POS_W'(step)
                                    : cur_pos + ssc_pkg::POS_W'(step);
               if ($urandom_range(0, 29) == 0)
                  cur_pos = ($urandom_range(0, 1) == 1) ? '1 : '0;
               send_request(1'b0, cur_pos, cur_time);
               n++;
            end
            if (n < count && $urandom_range(0, 2) == 0) begin
               send_request(1'b1, ssc_pkg::POS_W'($urandom()), $urandom());
               n++;
            end
         end
      end
   endtask

   initial begin : stimulus
      csr_set_type s;
      int          phase;
      sb               = new();
      burst_left       = 0;
      req_held         = 1'b0;
      settings_applied = 0;
      cur_time         = '0;
      cur_pos          = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (phase = 0; phase < PHASES; phase++) begin
         settle();
         s = pick_settings(phase);
         apply_settings(s);
         run_random(PHASE_ITEMS);
      end
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d responses for %0d requests over %0d register settings, %0d errors",
               sb.responses, sb.requests, settings_applied, sb.errors);
      $display("Expected classes: idle %0d, slow %0d, fast %0d, fling %0d",
               sb.class_count[ssc_pkg::CLS_IDLE], sb.class_count[ssc_pkg::CLS_SLOW],
               sb.class_count[ssc_pkg::CLS_FAST], sb.class_count[ssc_pkg::CLS_FLING]);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
